// File: rtl/mh32_pkg.sv
`default_nettype none

package mh32_pkg;

   // Block geometry of the two hashing modes.
   localparam logic [3:0] BYTES_PER_BLOCK = 4'd12;
   localparam logic [3:0] WORDS_PER_BLOCK = 4'd3;

   // Job queue between the packer and the mixer (depth must be a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // The mix is nine rounds, each updating one accumulator.
   localparam logic [3:0] MIX_ROUNDS = 4'd9;

   // One unit of work for the mixer: add the three words (and the count into c), then mix.
   typedef struct packed {
      logic        final_job;
      logic [31:0] a_add;
      logic [31:0] b_add;
      logic [31:0] c_add;
      logic [31:0] count;
   } job_type;

   // Which of the two job slots the packer fills in a cycle.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

`default_nettype wire

// File: rtl/mix_hash_32_stream.sv
`default_nettype none

// Streaming 32-bit hash of the lookup2 family with zero-seeded accumulators.
// Input channel req_*: one message element per item (req_data), req_last marks
// the final item, and req_empty_req marks an item that carries no element, so
// an empty item with req_last ends a message (also a zero-length one).
// Result channel rsp_*: one item carrying rsp_hash per message.
// csr_we/csr_wdata write word_mode (0 bytes, 1 words) and drop any message in
// progress; write only while the block is idle.
// A packer takes one item per clock while the job queue has room and queues
// block and final jobs; a mixer runs a block job as one add step, then nine
// one-row mix rounds, and a final job as those steps plus a flush step that
// hands the hash to the output register. Inside a byte-mode message the input
// keeps up with one item per clock, and each message end adds a final job for
// the mixer; in word mode the mixer limits the rate. The input stalls while
// fewer than two of the four job queue entries are free. A message's result
// waits behind any jobs queued ahead of its final job. While the receiver
// stalls, the mixer holds the next finished hash and the queue and packer keep
// filling until the queue is full. Reset selects byte mode and clears the
// message, queue and mixer control state; queue entries and the hash are not reset.
module mix_hash_32_stream (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_wdata,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_data,
   input  wire         req_last,
   input  wire         req_empty_req,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_hash
);

   mh32_pkg::push_type push;
   mh32_pkg::job_type  push_job0;
   mh32_pkg::job_type  push_job1;
   mh32_pkg::job_type  head;
   logic               head_valid;
   logic               room2;
   logic               pop;

   // Front: packs elements into blocks and issues jobs.
   mh32_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .req_last      (req_last),
      .req_empty_req (req_empty_req),
      .room2         (room2),
      .push          (push),
      .push_job0     (push_job0),
      .push_job1     (push_job1)
   );

   // Job queue decoupling the packer from the mixer.
   mh32_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job0  (push_job0),
      .push_job1  (push_job1),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .room2      (room2)
   );

   // Back: accumulates, mixes and returns the hash.
   mh32_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_clear  (csr_we),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_hash   (rsp_hash)
   );

endmodule

`default_nettype wire

// File: rtl/mh32_queue.sv
`default_nettype none

module mh32_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  mh32_pkg::push_type    push,
   input  mh32_pkg::job_type     push_job0,
   input  mh32_pkg::job_type     push_job1,
   input  wire                   pop,
   output mh32_pkg::job_type     head,
   output logic                  head_valid,
   output logic                  room2
);

   mh32_pkg::job_type                   entry_ff [mh32_pkg::QUEUE_DEPTH];
   logic [mh32_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mh32_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mh32_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic [mh32_pkg::QPTR_W-1:0]         wr_ptr_plus1;
   logic [mh32_pkg::QCNT_W-1:0]         push_cnt;
   logic [mh32_pkg::QCNT_W-1:0]         pop_cnt;

   // Status toward both sides.
   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign room2      = (count_ff <= mh32_pkg::QCNT_W'(mh32_pkg::QUEUE_DEPTH - 2));

   // Pointer and fill bookkeeping; up to two jobs enter in one cycle.
   always_comb begin
      wr_ptr_plus1 = wr_ptr_ff + 1'b1;
      push_cnt     = mh32_pkg::QCNT_W'(push.first) + mh32_pkg::QCNT_W'(push.second);
      pop_cnt      = mh32_pkg::QCNT_W'(pop);
      wr_ptr_in    = wr_ptr_ff + mh32_pkg::QPTR_W'(push_cnt);
      rd_ptr_in    = rd_ptr_ff + mh32_pkg::QPTR_W'(pop_cnt);
      count_in     = count_ff + push_cnt - pop_cnt;
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= push_job0;
      end
      if (push.second) begin
         entry_ff[wr_ptr_plus1] <= push_job1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The packer must never push more than the free space.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.second |-> (push.first &&
         count_ff <= mh32_pkg::QCNT_W'(mh32_pkg::QUEUE_DEPTH - 2)))
      else $error("job queue overflow on double push");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue popped while empty");

endmodule

`default_nettype wire

// File: rtl/mh32_front.sv
`default_nettype none

module mh32_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire                   csr_wdata,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [31:0]           req_data,
   input  wire                   req_last,
   input  wire                   req_empty_req,
   input  wire                   room2,
   output mh32_pkg::push_type    push,
   output mh32_pkg::job_type     push_job0,
   output mh32_pkg::job_type     push_job1
);

   logic        word_mode_ff;
   logic [31:0] pend_ff [3];
   logic [31:0] pend_in [3];
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] pend_upd [3];
   logic [3:0]  pos_upd;
   logic [31:0] count_upd;
   logic        accept;
   logic        block_full;
   logic [31:0] tail0, tail1, tail2;
   mh32_pkg::job_type absorb_job;
   mh32_pkg::job_type final_job;

   // An item is taken only when the queue can hold a block job and a final job.
   assign req_ready = room2;
   assign accept    = req_valid && req_ready;

   // Pack the element into the pending block.
   always_comb begin
      pend_upd  = pend_ff;
      pos_upd   = pos_ff;
      count_upd = count_ff;
      if (!req_empty_req) begin
         if (word_mode_ff) begin
            pend_upd[pos_ff[1:0]] = req_data;
         end else begin
            pend_upd[pos_ff[3:2]] = pend_ff[pos_ff[3:2]] |
               ({24'd0, req_data[7:0]} << {pos_ff[1:0], 3'b000});
         end
         pos_upd   = pos_ff + 4'd1;
         count_upd = count_ff + 32'd1;
      end
      block_full = !req_empty_req && (word_mode_ff ?
         (pos_upd == mh32_pkg::WORDS_PER_BLOCK) : (pos_upd == mh32_pkg::BYTES_PER_BLOCK));
   end

   // Build the full-block job and the final job.
   always_comb begin
      absorb_job.final_job = 1'b0;
      absorb_job.a_add     = pend_upd[0];
      absorb_job.b_add     = pend_upd[1];
      absorb_job.c_add     = pend_upd[2];
      absorb_job.count     = '0;

      // A block that has just been absorbed leaves an empty tail.
      tail0 = block_full ? 32'd0 : pend_upd[0];
      tail1 = block_full ? 32'd0 : pend_upd[1];
      tail2 = block_full ? 32'd0 : pend_upd[2];

      final_job.final_job = 1'b1;
      final_job.a_add     = tail0;
      final_job.b_add     = tail1;
      final_job.c_add     = word_mode_ff ? 32'd0 : {tail2[23:0], 8'h00};
      final_job.count     = count_upd;
   end

   // Queue pushes: a full block goes first, the final job behind it.
   always_comb begin
      push.first  = accept && (block_full || req_last);
      push.second = accept && block_full && req_last;
      push_job0   = block_full ? absorb_job : final_job;
      push_job1   = final_job;
   end

   // Message state for the next cycle.
   always_comb begin
      pend_in  = pend_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      if (csr_we) begin
         pend_in  = '{default: 32'd0};
         pos_in   = '0;
         count_in = '0;
      end else if (accept) begin
         if (req_last) begin
            pend_in  = '{default: 32'd0};
            pos_in   = '0;
            count_in = '0;
         end else if (block_full) begin
            pend_in  = '{default: 32'd0};
            pos_in   = '0;
            count_in = count_upd;
         end else begin
            pend_in  = pend_upd;
            pos_in   = pos_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_mode_ff <= 1'b0;
         pend_ff      <= '{default: 32'd0};
         pos_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            word_mode_ff <= csr_wdata;
         end
         pend_ff  <= pend_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mh32_back.sv
`default_nettype none

module mh32_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_clear,
   input  mh32_pkg::job_type     head,
   input  wire                   head_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [31:0]           rsp_hash
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_FLUSH
   } state_type;

   state_type   state_ff;
   logic [3:0]  round_ff;
   logic        final_ff;
   logic [31:0] a_ff, b_ff, c_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_hash_ff;
   logic [31:0] a_in, b_in, c_in;
   logic [31:0] a_load, b_load, c_load;
   logic        slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && head_valid && !csr_clear;

   // Add the job's words into the accumulators, and the job's count into c.
   always_comb begin
      a_load = a_ff + head.a_add;
      b_load = b_ff + head.b_add;
      c_load = c_ff + head.c_add + head.count;
   end

   // One mix round per cycle; the round picks the accumulator and shift.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      case (round_ff)
         4'd0:    a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 13);
         4'd1:    b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 8);
         4'd2:    c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 13);
         4'd3:    a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 12);
         4'd4:    b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 16);
         4'd5:    c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 5);
         4'd6:    a_in = (a_ff - b_ff - c_ff) ^ (c_ff >> 3);
         4'd7:    b_in = (b_ff - c_ff - a_ff) ^ (a_ff << 10);
         4'd8:    c_in = (c_ff - a_ff - b_ff) ^ (b_ff >> 15);
         default: a_in = a_ff;
      endcase
   end

   // Sequencer, accumulators and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         final_ff     <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The flush step sets the result itself, so the drop is skipped there.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FLUSH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (csr_clear) begin
                  a_ff <= '0;
                  b_ff <= '0;
                  c_ff <= '0;
               end else if (head_valid) begin
                  a_ff     <= a_load;
                  b_ff     <= b_load;
                  c_ff     <= c_load;
                  final_ff <= head.final_job;
                  round_ff <= '0;
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: begin
               a_ff <= a_in;
               b_ff <= b_in;
               c_ff <= c_in;
               if (round_ff == mh32_pkg::MIX_ROUNDS - 4'd1) begin
                  round_ff <= '0;
                  state_ff <= final_ff ? ST_FLUSH : ST_IDLE;
               end else begin
                  round_ff <= round_ff + 4'd1;
               end
            end
            ST_FLUSH: begin
               // Hand c to the result register and start the next message clean.
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hash_ff  <= c_ff;
                  a_ff         <= '0;
                  b_ff         <= '0;
                  c_ff         <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FLUSH))
      else $error("result raised outside the flush step");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> (round_ff < mh32_pkg::MIX_ROUNDS))
      else $error("mix round counter out of range");

   a_clear_after_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && slot_free) |=> (a_ff == '0 && b_ff == '0 && c_ff == '0))
      else $error("accumulators not cleared after a result");

endmodule

`default_nettype wire
